### src/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types and constants shared by the sector region router.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

  // Regions in the layout, and registers in the config file.
  localparam int REGION_COUNT = 8;
  localparam int NUM_REGS     = 8;

  localparam int REGION_IDX_W = $clog2(REGION_COUNT);
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int CFG_INDEX_W  = REG_IDX_W + 1;   // room for out-of-range indexes

  localparam int SECTOR_W     = 32;
  localparam int COUNT_W      = 16;
  localparam int LEN_W        = 23;
  localparam int OUT_IDX_W    = 3;
  // Region ends never exceed the sum of all region lengths.
  localparam int SUM_W        = LEN_W + $clog2(REGION_COUNT);

  // Reset lengths: boot record one sector, root directory two sectors.
  localparam int BOOT_REG     = 0;
  localparam int ROOT_REG     = 3;
  localparam logic [LEN_W-1:0] BOOT_RESET_LEN = LEN_W'(1);
  localparam logic [LEN_W-1:0] ROOT_RESET_LEN = LEN_W'(2);

  typedef struct packed {
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  sector_count;
  } srr_req_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] region_index;
    logic [LEN_W-1:0]     region_offset;
    logic [COUNT_W-1:0]   run_count;
    logic [COUNT_W-1:0]   transfer_position;
    logic                 covered;
    logic                 last_run;
  } srr_run_t;

endpackage

`default_nettype wire

### src/sector_region_router.sv
// ----------------------------------------------------------------------------
// sector_region_router
// Splits a transfer request into runs over up to eight end-to-end regions.
// ----------------------------------------------------------------------------
// A request is taken when the block is idle; it then walks the regions one
// per cycle, except while a run waits on an output register held by out_stall,
// with a single add/compare/subtract unit, keeping a running region start, and
// emits one run for each region the transfer overlaps, followed by one
// uncovered run for any remainder past the last region (or an empty uncovered
// run for a zero-sector request). A request is accepted in ST_IDLE, then walks
// in ST_WALK (skipped for a zero-sector request) and ends in ST_TAIL unless
// the transfer ends inside a region. The region walk is the limiting loop.
// in_stall is high while a request is in progress. Region lengths are written
// through the cfg port (index 0..7; higher indexes are ignored); the user must
// write them only while the block is idle, which the block does not enforce.
`default_nettype none

module sector_region_router (
  input  wire                              clk,
  input  wire                              rst_n,

  input  wire                              in_valid,
  output logic                             in_stall,
  input  srr_pkg::srr_req_t                in_data,

  output logic                             out_valid,
  input  wire                              out_stall,
  output srr_pkg::srr_run_t                out_data,

  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [srr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [srr_pkg::LEN_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL
  } state_t;

  state_t state_r, state_nxt;

  logic [srr_pkg::LEN_W-1:0]        len_r [srr_pkg::NUM_REGS];

  logic [srr_pkg::SECTOR_W-1:0]     cur_r, cur_nxt;
  logic [srr_pkg::COUNT_W-1:0]      left_r, left_nxt;
  logic [srr_pkg::COUNT_W-1:0]      pos_r, pos_nxt;
  logic [srr_pkg::SUM_W-1:0]        start_r, start_nxt;
  logic [srr_pkg::REGION_IDX_W-1:0] idx_r, idx_nxt;

  logic                             out_valid_r, out_valid_nxt;
  srr_pkg::srr_run_t                out_data_r, out_data_nxt;

  logic                             out_free;
  logic                             in_take;
  logic                             cfg_take;
  logic [srr_pkg::LEN_W-1:0]        len_sel;
  logic [srr_pkg::SUM_W-1:0]        end_sum;
  logic [srr_pkg::SECTOR_W-1:0]     start_ext;
  logic [srr_pkg::SECTOR_W-1:0]     end_ext;
  logic                             hit;
  logic [srr_pkg::SECTOR_W-1:0]     room;
  logic [srr_pkg::COUNT_W-1:0]      run;
  logic [srr_pkg::SECTOR_W-1:0]     offset;
  logic                             last_region;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Shared unit: region end, overlap test, run length.
  always_comb begin
    len_sel     = len_r[srr_pkg::REG_IDX_W'(idx_r)];
    end_sum     = start_r + srr_pkg::SUM_W'(len_sel);
    start_ext   = srr_pkg::SECTOR_W'(start_r);
    end_ext     = srr_pkg::SECTOR_W'(end_sum);
    hit         = (cur_r >= start_ext) && (cur_r < end_ext);
    room        = end_ext - cur_r;
    run         = (room > srr_pkg::SECTOR_W'(left_r)) ? left_r
                                                      : srr_pkg::COUNT_W'(room);
    offset      = cur_r - start_ext;
    last_region = (idx_r == srr_pkg::REGION_IDX_W'(srr_pkg::REGION_COUNT - 1));
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cur_nxt   = in_data.start_sector;
          left_nxt  = in_data.sector_count;
          pos_nxt   = '0;
          start_nxt = '0;
          idx_nxt   = '0;
          // zero-sector request goes straight to an empty uncovered run
          state_nxt = (in_data.sector_count == '0) ? ST_TAIL : ST_WALK;
        end
      end

      ST_WALK: begin
        if (hit && !out_free) begin
          // hold this region until the output register frees up
        end else begin
          if (hit) begin
            out_valid_nxt                  = 1'b1;
            out_data_nxt.region_index      = srr_pkg::OUT_IDX_W'(idx_r);
            out_data_nxt.region_offset     = srr_pkg::LEN_W'(offset);
            out_data_nxt.run_count         = run;
            out_data_nxt.transfer_position = pos_r;
            out_data_nxt.covered           = 1'b1;
            out_data_nxt.last_run          = (left_r == run);
            cur_nxt  = cur_r + srr_pkg::SECTOR_W'(run);
            left_nxt = left_r - run;
            pos_nxt  = pos_r + run;
          end
          start_nxt = end_sum;
          idx_nxt   = idx_r + srr_pkg::REGION_IDX_W'(1);
          if (hit && (left_r == run)) begin
            state_nxt = ST_IDLE;
          end else if (last_region) begin
            state_nxt = ST_TAIL;
          end
        end
      end

      ST_TAIL: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.region_index      = '0;
          out_data_nxt.region_offset     = '0;
          out_data_nxt.run_count         = left_r;
          out_data_nxt.transfer_position = pos_r;
          out_data_nxt.covered           = 1'b0;
          out_data_nxt.last_run          = 1'b1;
          state_nxt                      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < srr_pkg::NUM_REGS; i++) begin
        len_r[i] <= '0;
      end
      len_r[srr_pkg::BOOT_REG] <= srr_pkg::BOOT_RESET_LEN;
      len_r[srr_pkg::ROOT_REG] <= srr_pkg::ROOT_RESET_LEN;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_take && (cfg_index < srr_pkg::CFG_INDEX_W'(srr_pkg::NUM_REGS))) begin
        len_r[cfg_index[srr_pkg::REG_IDX_W-1:0]] <= cfg_data;
      end
    end
    cur_r      <= cur_nxt;
    left_r     <= left_nxt;
    pos_r      <= pos_nxt;
    start_r    <= start_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_covered_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.covered |-> out_data_r.run_count != '0)
    else $error("covered run with zero length");

  a_uncovered_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.covered |-> out_data_r.last_run)
    else $error("uncovered run not marked last");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.covered |->
      int'(out_data_r.region_index) < srr_pkg::REGION_COUNT)
    else $error("covered run names a region outside the layout");

  a_walk_conserves: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && state_r == ST_WALK && $past(state_r) == ST_WALK |->
      ({1'b0, pos_r} + {1'b0, left_r}) ==
      ($past({1'b0, pos_r}) + $past({1'b0, left_r})))
    else $error("position plus remaining count changed during walk");

endmodule

`default_nettype wire

### bench/tb_sector_region_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_region_router
// Self-checking bench for the sector region router.
// ----------------------------------------------------------------------------
// A table of directed requests runs against the reset layout. Runs that are
// easy to derive by hand are typed into the table, and the other rows use the
// run predictor. Random phases follow. Each phase loads a new region layout:
// small, all maximum, all empty, mixed, or holes at the start. Each phase
// then sends requests aimed at region edges and across the whole sector
// range. Both sides idle at random. Each run is checked in order against the
// predicted runs.
// ----------------------------------------------------------------------------
module tb_sector_region_router;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = srr_pkg::REGION_COUNT + 2;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;
  localparam int DIR_ROWS        = 16;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 25;
  localparam logic [srr_pkg::LEN_W-1:0] LEN_MAX = '1;

  typedef enum int {
    LAYOUT_SMALL,
    LAYOUT_MAX,
    LAYOUT_EMPTY,
    LAYOUT_MIXED,
    LAYOUT_HOLES
  } layout_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  srr_pkg::srr_req_t               in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  srr_pkg::srr_run_t               out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [srr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [srr_pkg::LEN_W-1:0]       cfg_data = '0;

  // Bench copy of the region lengths, updated on each accepted in-range cfg write.
  logic [srr_pkg::LEN_W-1:0] region_len [srr_pkg::NUM_REGS];
  srr_pkg::srr_run_t         pending_runs [$];
  // Per request: number of hand-typed runs, or 0 to use the predictor.
  int                        preset_counts [$];
  srr_pkg::srr_run_t         preset_runs [$];

  srr_pkg::srr_req_t dir_req  [DIR_ROWS];
  int                dir_nexp [DIR_ROWS];
  srr_pkg::srr_run_t dir_runs [DIR_ROWS][3];

  int errors = 0;
  int cycles = 0;
  int out_hold = 0;
  logic out_hold_stall = 1'b0;

  sector_region_router dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic srr_pkg::srr_run_t mk_run(
      input logic [srr_pkg::OUT_IDX_W-1:0] idx,
      input logic [srr_pkg::LEN_W-1:0] off,
      input logic [srr_pkg::COUNT_W-1:0] cnt,
      input logic [srr_pkg::COUNT_W-1:0] pos,
      input logic cov, input logic last);
    srr_pkg::srr_run_t r;
    r.region_index      = idx;
    r.region_offset     = off;
    r.run_count         = cnt;
    r.transfer_position = pos;
    r.covered           = cov;
    r.last_run          = last;
    return r;
  endfunction

  // Walk the regions in order. Emit one run per overlapped region, then any
  // uncovered rest, or an empty run for a zero count. Final run has last_run.
  function automatic void split_request(input srr_pkg::srr_req_t req);
    longint unsigned cur, left, pos, rstart, rend, span;
    srr_pkg::srr_run_t runs [$];
    srr_pkg::srr_run_t tail;
    int i;
    cur  = req.start_sector;
    left = req.sector_count;
    pos  = 0;
    rstart = 0;
    if (left == 0) begin
      pending_runs.push_back(mk_run('0, '0, '0, '0, 1'b0, 1'b1));
      return;
    end
    for (i = 0; i < srr_pkg::REGION_COUNT; i++) begin
      rend = rstart + region_len[i];
      if (cur >= rstart && cur < rend) begin
        span = rend - cur;
        if (span > left)
          span = left;
        runs.push_back(mk_run(srr_pkg::OUT_IDX_W'(i), srr_pkg::LEN_W'(cur - rstart),
                              srr_pkg::COUNT_W'(span), srr_pkg::COUNT_W'(pos),
                              1'b1, 1'b0));
        cur  += span;
        left -= span;
        pos  += span;
      end
      if (left == 0)
        break;
      rstart = rend;
    end
    if (left > 0)
      runs.push_back(mk_run('0, '0, srr_pkg::COUNT_W'(left), srr_pkg::COUNT_W'(pos),
                            1'b0, 1'b0));
    tail = runs[runs.size()-1];
    tail.last_run = 1'b1;
    runs[runs.size()-1] = tail;
    foreach (runs[k])
      pending_runs.push_back(runs[k]);
  endfunction

  function automatic int pick_idle();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return 0;
    else if (pick < 88)
      return $urandom_range(1, 3);
    else
      return $urandom_range(6, 30);
  endfunction

  function automatic srr_pkg::srr_req_t random_request();
    longint unsigned total, edge_at;
    int pick, k, j;
    srr_pkg::srr_req_t r;
    total = 0;
    for (j = 0; j < srr_pkg::REGION_COUNT; j++)
      total += region_len[j];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.start_sector = $urandom_range(0, 32'(total + 3));
    end else if (pick < 80) begin
      // land just before, on, or just after a region boundary
      k = $urandom_range(0, srr_pkg::REGION_COUNT);
      edge_at = 0;
      for (j = 0; j < k; j++)
        edge_at += region_len[j];
      if (edge_at == 0)
        r.start_sector = $urandom_range(0, 1);
      else
        r.start_sector = 32'(edge_at - 1 + $urandom_range(0, 2));
    end else begin
      r.start_sector = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8)
      r.sector_count = '0;
    else if (pick < 70)
      r.sector_count = srr_pkg::COUNT_W'($urandom_range(1, 24));
    else if (pick < 90)
      r.sector_count = srr_pkg::COUNT_W'($urandom_range(1, 300));
    else
      r.sector_count = srr_pkg::COUNT_W'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_request(input srr_pkg::srr_req_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [srr_pkg::LEN_W-1:0] val,
                           input int gap);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // The first wait lets the monitor log the last accepted request first.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_layout(input layout_mode_t mode);
    logic [srr_pkg::LEN_W-1:0] len;
    int k, pick;
    wait_idle();
    for (k = 0; k < srr_pkg::NUM_REGS; k++) begin
      pick = $urandom_range(0, 9);
      case (mode)
        LAYOUT_SMALL: len = (pick < 3) ? '0 : srr_pkg::LEN_W'($urandom_range(1, 12));
        LAYOUT_MAX:   len = LEN_MAX;
        LAYOUT_EMPTY: len = '0;
        LAYOUT_MIXED: begin
          if (pick < 2)      len = '0;
          else if (pick < 4) len = srr_pkg::LEN_W'(1);
          else if (pick < 6) len = srr_pkg::LEN_W'($urandom_range(2, 12));
          else if (pick < 8) len = LEN_MAX;
          else               len = srr_pkg::LEN_W'($urandom);
        end
        default: len = (k < srr_pkg::NUM_REGS / 2) ? '0
                                                   : srr_pkg::LEN_W'($urandom_range(1, 12));
      endcase
      write_reg(srr_pkg::CFG_INDEX_W'(k), len, $urandom_range(0, 2));
    end
    // out-of-range index last, so an aliasing bug is not overwritten
    write_reg(srr_pkg::CFG_INDEX_W'($urandom_range(srr_pkg::NUM_REGS,
                                                   2**srr_pkg::CFG_INDEX_W - 1)),
              srr_pkg::LEN_W'($urandom), $urandom_range(0, 2));
    cfg_valid <= 1'b0;
  endtask

  // Directed table, reset layout: region 0 = sector 0, region 3 = sectors 1..2.
  initial begin
    dir_req[0]  = {32'd0, 16'd0};
    dir_nexp[0] = 1;
    dir_runs[0][0] = mk_run('0, '0, 16'd0, 16'd0, 1'b0, 1'b1);
    dir_req[1]  = {32'd0, 16'd1};
    dir_nexp[1] = 1;
    dir_runs[1][0] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::BOOT_REG), '0, 16'd1, 16'd0,
                            1'b1, 1'b1);
    dir_req[2]  = {32'd0, 16'd3};
    dir_nexp[2] = 2;
    dir_runs[2][0] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::BOOT_REG), '0, 16'd1, 16'd0,
                            1'b1, 1'b0);
    dir_runs[2][1] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::ROOT_REG), '0, 16'd2, 16'd1,
                            1'b1, 1'b1);
    dir_req[3]  = {32'd0, 16'hFFFF};
    dir_nexp[3] = 3;
    dir_runs[3][0] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::BOOT_REG), '0, 16'd1, 16'd0,
                            1'b1, 1'b0);
    dir_runs[3][1] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::ROOT_REG), '0, 16'd2, 16'd1,
                            1'b1, 1'b0);
    dir_runs[3][2] = mk_run('0, '0, 16'd65532, 16'd3, 1'b0, 1'b1);
    dir_req[4]  = {32'hFFFF_FFFF, 16'hFFFF};
    dir_nexp[4] = 1;
    dir_runs[4][0] = mk_run('0, '0, 16'hFFFF, 16'd0, 1'b0, 1'b1);
    dir_req[5]  = {32'hFFFF_FFFF, 16'd0};
    dir_nexp[5] = 1;
    dir_runs[5][0] = mk_run('0, '0, 16'd0, 16'd0, 1'b0, 1'b1);
    dir_req[6]  = {32'd3, 16'd1};
    dir_nexp[6] = 1;
    dir_runs[6][0] = mk_run('0, '0, 16'd1, 16'd0, 1'b0, 1'b1);
    dir_req[7]  = {32'd2, 16'd5};
    dir_nexp[7] = 2;
    dir_runs[7][0] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::ROOT_REG), srr_pkg::LEN_W'(1),
                            16'd1, 16'd0, 1'b1, 1'b0);
    dir_runs[7][1] = mk_run('0, '0, 16'd4, 16'd1, 1'b0, 1'b1);
    dir_req[8]  = {32'd1, 16'd1};
    dir_nexp[8] = 1;
    dir_runs[8][0] = mk_run(srr_pkg::OUT_IDX_W'(srr_pkg::ROOT_REG), '0, 16'd1, 16'd0,
                            1'b1, 1'b1);
    dir_req[9]  = {32'd1, 16'd2};
    dir_req[10] = {32'd0, 16'd2};
    dir_req[11] = {32'd2, 16'd1};
    dir_req[12] = {32'h8000_0000, 16'h8000};
    dir_req[13] = {32'h5555_5555, 16'hAAAA};
    dir_req[14] = {32'hAAAA_AAAA, 16'h5555};
    dir_req[15] = {32'd2, 16'hFFFF};
    for (int r = 9; r < DIR_ROWS; r++)
      dir_nexp[r] = 0;
  end

  initial begin
    int row, j, phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DIR_ROWS; row++) begin
      preset_counts.push_back(dir_nexp[row]);
      for (j = 0; j < dir_nexp[row]; j++)
        preset_runs.push_back(dir_runs[row][j]);
      send_request(dir_req[row], pick_idle());
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      program_layout(layout_mode_t'(phase % 5));
      repeat (ITEMS_PER_PHASE) begin
        preset_counts.push_back(0);
        send_request(random_request(), pick_idle());
      end
    end

    wait_idle();
    if (errors == 0 && pending_runs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: alternate free-running and stalled stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
    end else begin
      out_hold_stall = !out_hold_stall;
      if (out_hold_stall)
        out_hold = pick_idle();
      else
        out_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      out_stall <= out_hold_stall && (out_hold > 0);
      if (out_hold > 0)
        out_hold--;
    end
  end

  always @(posedge clk) begin
    srr_pkg::srr_run_t want;
    int typed_n;
    if (!rst_n) begin
      foreach (region_len[k])
        region_len[k] = '0;
      region_len[srr_pkg::BOOT_REG] = srr_pkg::BOOT_RESET_LEN;
      region_len[srr_pkg::ROOT_REG] = srr_pkg::ROOT_RESET_LEN;
    end else begin
      if (cfg_valid && cfg_ready &&
          cfg_index < srr_pkg::CFG_INDEX_W'(srr_pkg::NUM_REGS))
        region_len[cfg_index[srr_pkg::REG_IDX_W-1:0]] = cfg_data;
      if (in_valid && !in_stall) begin
        typed_n = (preset_counts.size() != 0) ? preset_counts.pop_front() : 0;
        if (typed_n == 0)
          split_request(in_data);
        else
          repeat (typed_n) pending_runs.push_back(preset_runs.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (pending_runs.size() == 0) begin
          note_error($sformatf("unexpected run idx=%0d off=%0d cnt=%0d pos=%0d",
                               out_data.region_index, out_data.region_offset,
                               out_data.run_count, out_data.transfer_position));
        end else begin
          want = pending_runs.pop_front();
          if (out_data.region_index !== want.region_index ||
              out_data.region_offset !== want.region_offset ||
              out_data.run_count !== want.run_count ||
              out_data.transfer_position !== want.transfer_position ||
              out_data.covered !== want.covered ||
              out_data.last_run !== want.last_run)
            note_error($sformatf({"run mismatch: exp idx=%0d off=%0d cnt=%0d pos=%0d ",
                                  "cov=%0b last=%0b, got idx=%0d off=%0d cnt=%0d ",
                                  "pos=%0d cov=%0b last=%0b"},
                                 want.region_index, want.region_offset, want.run_count,
                                 want.transfer_position, want.covered, want.last_run,
                                 out_data.region_index, out_data.region_offset,
                                 out_data.run_count, out_data.transfer_position,
                                 out_data.covered, out_data.last_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

### filelist.f
src/srr_pkg.sv
src/sector_region_router.sv
bench/tb_sector_region_router.sv
